// ===== design/multi_queue_priority_scheduler_unit_macros.svh =====
// assertion macros for the multi-queue priority scheduler
// used by the top level, which provides clk_i and rst_ni
`ifndef MULTI_QUEUE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define MULTI_QUEUE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define MQPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mqps_pkg.sv =====
// types and constants for the multi-queue priority scheduler
// no dependencies
package mqps_pkg;

  localparam int unsigned QN_W  = 4;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned PRI_W = 16;
  localparam int unsigned ID_W  = 16;

  typedef enum logic [1:0] {
    FUNC_ASSIGN  = 2'd0,
    FUNC_MERGE   = 2'd1,
    FUNC_EXECUTE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_SIZE     = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_MERGE    = 3'd2,
    KIND_EXEC     = 3'd3,
    KIND_EMPTY    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ASSIGN_CHK,
    ST_FREE,
    ST_MERGE_CHK,
    ST_MERGE_SUM,
    ST_RELABEL,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [QN_W-1:0]  owner;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  tsk;
  } slot_t;

  typedef struct packed {
    logic             found;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  tsk;
  } best_t;

endpackage

// ===== design/mqps_if.sv =====
// valid/ready channels for command beats and result beats
// depends on mqps_pkg
interface mqps_in_if import mqps_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [QN_W-1:0]  target_queue;
  logic [QN_W-1:0]  source_queue;
  logic [ID_W-1:0]  task_id;
  logic [PRI_W-1:0] task_priority;

  modport source (output valid, func, target_queue, source_queue, task_id,
                  task_priority, input ready);
  modport sink (input valid, func, target_queue, source_queue, task_id,
                task_priority, output ready);
endinterface

interface mqps_out_if import mqps_pkg::*;;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [QN_W-1:0]  queue_number;
  logic [CNT_W-1:0] task_count;
  logic [PRI_W-1:0] top_priority;
  logic [ID_W-1:0]  done_task;
  logic             last;

  modport source (output valid, kind, queue_number, task_count, top_priority,
                  done_task, last, input ready);
  modport sink (input valid, kind, queue_number, task_count, top_priority,
                done_task, last, output ready);
endinterface

// ===== design/multi_queue_priority_scheduler_unit.sv =====
// assign searches the pool for a free slot; merge relabels the source queue's slots,
// unless source and target are the same, and then scans the target; execute scans once
// per task removed and once more (a single scan on an empty queue); one pool slot visited per cycle through a
// single memory read port and one shared compare unit; one command at a time
// reset: used bits, queue fills, threshold and control clear at once, no clearing pass
`include "multi_queue_priority_scheduler_unit_macros.svh"
module multi_queue_priority_scheduler_unit import mqps_pkg::*; #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned POOL_SIZE   = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  mqps_in_if.sink          req_i,
  mqps_out_if.source       rsp_o
);

  localparam int unsigned PW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CW  = PW + 1;
  localparam int unsigned QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  state_e state_q, state_d, ret_q;

  logic [1:0]       func_q;
  logic [QN_W-1:0]  t_q, s_q;
  logic [ID_W-1:0]  id_q;
  logic [PRI_W-1:0] pri_q;
  logic [CNT_W-1:0] thr_q, fs_q;
  logic [CNT_W-1:0] fill_q [NUM_QUEUES];
  logic [POOL_SIZE-1:0] used_q;
  logic [CW-1:0]    cnt_q;
  logic [CNT_W-1:0] n_q;
  logic [PRI_W-1:0] top_q;
  logic [ID_W-1:0]  pend_tsk_q;
  logic             pend_q;

  // read pipeline stage
  slot_t            mem [POOL_SIZE];
  slot_t            rd_q;
  logic             used_rd_q, pv_q;
  logic [PW-1:0]    pidx_q;

  kind_e            res_kind_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic [PRI_W-1:0] res_pri_q;
  logic [ID_W-1:0]  res_tsk_q;
  logic             res_last_q;

  logic             ov_q;
  kind_e            o_kind_q;
  logic [QN_W-1:0]  o_q_q;
  logic [CNT_W-1:0] o_cnt_q;
  logic [PRI_W-1:0] o_pri_q;
  logic [ID_W-1:0]  o_tsk_q;
  logic             o_last_q;

  best_t         best;
  logic [PW-1:0] best_idx;

  logic [QIW-1:0]   tq_idx, sq_idx, fidx;
  logic [CNT_W-1:0] fill_rd;
  logic [CNT_W:0]   fill_sum;
  logic [PW-1:0]    cidx;
  logic             t_ok, s_ok, scan_end, out_free, accept;
  logic             exec_cont, best_clear, best_en;
  logic             mem_we;
  logic [PW-1:0]    mem_waddr;
  slot_t            mem_wdata;

  // ---------------- control outputs ----------------
  always_comb begin
    tq_idx    = QIW'(t_q);
    sq_idx    = QIW'(s_q);
    fidx      = (state_q == ST_MERGE_CHK) ? sq_idx : tq_idx;
    fill_rd   = fill_q[fidx];
    fill_sum  = {1'b0, fill_rd} + {1'b0, fs_q};
    cidx      = cnt_q[PW-1:0];
    t_ok      = 32'(t_q) < NUM_QUEUES;
    s_ok      = 32'(s_q) < NUM_QUEUES;
    scan_end  = cnt_q == CW'(POOL_SIZE);
    out_free  = !ov_q || rsp_o.ready;
    accept    = req_i.valid && req_i.ready;
    exec_cont = best.found && (!pend_q || ((best.pri == top_q) &&
                (n_q < CNT_W'(QUEUE_DEPTH))));
    best_en   = (state_q == ST_SCAN) && pv_q && used_rd_q && (rd_q.owner == t_q);
    best_clear = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cidx;
    mem_wdata = '{owner: t_q, pri: pri_q, tsk: id_q};
    unique case (state_q)
      ST_FREE: begin
        mem_we = !used_q[cidx];
      end
      ST_RELABEL: begin
        mem_we    = pv_q && used_rd_q && (rd_q.owner == s_q);
        mem_waddr = pidx_q;
        mem_wdata = '{owner: t_q, pri: rd_q.pri, tsk: rd_q.tsk};
        best_clear = scan_end;
      end
      ST_MERGE_CHK: best_clear = 1'b1;
      ST_DECIDE:    best_clear = 1'b1;
      ST_IDLE:      best_clear = 1'b1;
      default: ;
    endcase
  end

  assign req_i.ready = state_q == ST_IDLE;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority case (req_i.func)
            FUNC_ASSIGN:  state_d = ST_ASSIGN_CHK;
            FUNC_MERGE:   state_d = ST_MERGE_CHK;
            FUNC_EXECUTE: state_d = (32'(req_i.target_queue) < NUM_QUEUES) ? ST_SCAN
                                                                            : ST_EMIT;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_ASSIGN_CHK: state_d = (!t_ok || fill_rd >= CNT_W'(QUEUE_DEPTH)) ? ST_EMIT : ST_FREE;
      ST_FREE: begin
        if (!used_q[cidx] || cnt_q == CW'(POOL_SIZE - 1)) state_d = ST_EMIT;
      end
      ST_MERGE_CHK: begin
        if (!t_ok || !s_ok || fill_rd < thr_q) state_d = ST_EMIT;
        else if (s_q == t_q)                 state_d = ST_SCAN;
        else                                 state_d = ST_MERGE_SUM;
      end
      ST_MERGE_SUM: state_d = (fill_sum > (CNT_W+1)'(QUEUE_DEPTH)) ? ST_EMIT : ST_RELABEL;
      ST_RELABEL:   if (scan_end) state_d = ST_SCAN;
      ST_SCAN:      if (scan_end) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (func_q == FUNC_EXECUTE && !pend_q && best.found) state_d = ST_SCAN;
        else                                                 state_d = ST_EMIT;
      end
      ST_EMIT:      if (out_free) state_d = ret_q;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- slot memory ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q      <= mem[cidx];
    used_rd_q <= used_q[cidx];
    pidx_q    <= cidx;
  end

  mqps_best #(.PW(PW)) u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (best_clear),
    .en_i    (best_en),
    .pri_i   (rd_q.pri),
    .tsk_i   (rd_q.tsk),
    .idx_i   (pidx_q),
    .best_o  (best),
    .idx_o   (best_idx)
  );

  // ---------------- datapath and control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      used_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) fill_q[i] <= '0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      pend_q <= 1'b0;
      n_q    <= '0;
      ret_q  <= ST_IDLE;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      pv_q <= ((state_q == ST_SCAN) || (state_q == ST_RELABEL)) && !scan_end;
      if ((state_q == ST_SCAN || state_q == ST_RELABEL) && !scan_end) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (ov_q && rsp_o.ready) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
          n_q    <= '0;
          ret_q  <= ST_IDLE;
          res_cnt_q  <= '0;
          res_pri_q  <= '0;
          res_tsk_q  <= '0;
          res_last_q <= 1'b1;
          res_kind_q <= KIND_EMPTY;
        end
        ST_ASSIGN_CHK: res_kind_q <= KIND_OVERFLOW;
        ST_FREE: begin
          if (!used_q[cidx]) begin
            used_q[cidx]   <= 1'b1;
            fill_q[tq_idx] <= fill_rd + CNT_W'(1);
            res_kind_q     <= KIND_SIZE;
            res_cnt_q      <= fill_rd + CNT_W'(1);
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_MERGE_CHK: begin
          fs_q       <= fill_rd;
          res_kind_q <= KIND_REFUSED;
        end
        ST_MERGE_SUM: begin
          res_kind_q <= KIND_OVERFLOW;
          if (fill_sum <= (CNT_W+1)'(QUEUE_DEPTH)) begin
            fill_q[tq_idx] <= fill_sum[CNT_W-1:0];
            fill_q[sq_idx] <= '0;
          end
        end
        ST_RELABEL: if (scan_end) cnt_q <= '0;
        ST_DECIDE: begin
          cnt_q <= '0;
          if (func_q == FUNC_MERGE) begin
            res_kind_q <= best.found ? KIND_MERGE : KIND_EMPTY;
            res_pri_q  <= best.found ? best.pri : '0;
          end else if (!pend_q && !best.found) begin
            res_kind_q <= KIND_EMPTY;
          end else begin
            res_kind_q <= KIND_EXEC;
            res_pri_q  <= top_q;
            res_tsk_q  <= pend_tsk_q;
            res_last_q <= !exec_cont;
            ret_q      <= exec_cont ? ST_SCAN : ST_IDLE;
            if (!pend_q) top_q <= best.pri;
            if (exec_cont) begin
              used_q[best_idx] <= 1'b0;
              if (fill_rd != '0) fill_q[tq_idx] <= fill_rd - CNT_W'(1);
              pend_q     <= 1'b1;
              pend_tsk_q <= best.tsk;
              n_q        <= n_q + CNT_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            o_kind_q <= res_kind_q;
            o_q_q    <= t_q;
            o_cnt_q  <= res_cnt_q;
            o_pri_q  <= res_pri_q;
            o_tsk_q  <= res_tsk_q;
            o_last_q <= res_last_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      t_q    <= req_i.target_queue;
      s_q    <= req_i.source_queue;
      id_q   <= req_i.task_id;
      pri_q  <= req_i.task_priority;
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.kind         = o_kind_q;
  assign rsp_o.queue_number = o_q_q;
  assign rsp_o.task_count   = o_cnt_q;
  assign rsp_o.top_priority = o_pri_q;
  assign rsp_o.done_task    = o_tsk_q;
  assign rsp_o.last         = o_last_q;

  `MQPS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(POOL_SIZE), "scan counter past pool")
  `MQPS_ASSERT_IMP(a_fill_range, t_ok, fill_q[tq_idx] <= CNT_W'(QUEUE_DEPTH), "fill past depth")
  `MQPS_ASSERT_IMP(a_empty_last, ov_q && o_kind_q == KIND_EMPTY, o_last_q, "empty not last")
  `MQPS_ASSERT_NXT(a_busy_after, accept && req_i.func != FUNC_NOP, state_q != ST_IDLE, "idle after cmd")

endmodule

// ===== design/mqps_best.sv =====
// running best-slot tracker: highest priority, then lowest task id, then first seen
// depends on mqps_pkg
module mqps_best import mqps_pkg::*; #(
  parameter int unsigned PW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             en_i,
  input  logic [PRI_W-1:0] pri_i,
  input  logic [ID_W-1:0]  tsk_i,
  input  logic [PW-1:0]    idx_i,
  output best_t            best_o,
  output logic [PW-1:0]    idx_o
);

  logic             found_q;
  logic [PRI_W-1:0] pri_q;
  logic [ID_W-1:0]  tsk_q;
  logic [PW-1:0]    idx_q;
  logic             take;

  assign take = en_i && (!found_q || (pri_i > pri_q) ||
                         ((pri_i == pri_q) && (tsk_i < tsk_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !clear_i) begin
      pri_q <= pri_i;
      tsk_q <= tsk_i;
      idx_q <= idx_i;
    end
  end

  assign best_o = '{found: found_q, pri: pri_q, tsk: tsk_q};
  assign idx_o  = idx_q;

endmodule

// ===== sim/tb_multi_queue_priority_scheduler_unit.sv =====
// testbench for the multi-queue priority scheduler: random and directed commands
// with a queue-level predictor and an in-order result scoreboard
// depends on mqps_pkg, mqps_if and the top level
module tb_multi_queue_priority_scheduler_unit;
  import mqps_pkg::*;

  localparam int NQ = 16;
  localparam int DEPTH = 64;
  localparam int POOL = 256;

  typedef struct packed {
    logic [2:0]       kind;
    logic [QN_W-1:0]  qnum;
    logic [CNT_W-1:0] cnt;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0]  tsk;
    logic             last;
  } result_t;

  class sched_scoreboard;
    bit              used[POOL];
    logic [3:0]      owner[POOL];
    logic [15:0]     spri[POOL];
    logic [15:0]     stask[POOL];
    int              fill[NQ];
    int              threshold;
    result_t         pending[$];
    int              errors;
    int              n_results;

    function void clear();
      foreach (used[i]) used[i] = 0;
      foreach (fill[i]) fill[i] = 0;
      threshold = 0;
      pending.delete();
      errors = 0;
      n_results = 0;
    endfunction

    function int top_slot(int q);
      int b;
      b = -1;
      for (int i = 0; i < POOL; i++) begin
        if (used[i] && owner[i] == q) begin
          if (b < 0 || spri[i] > spri[b] || (spri[i] == spri[b] && stask[i] < stask[b]))
            b = i;
        end
      end
      return b;
    endfunction

    function void push(logic [2:0] k, int q, int c, int p, int t, bit l);
      result_t r;
      r.kind = k; r.qnum = QN_W'(q); r.cnt = CNT_W'(c); r.pri = PRI_W'(p);
      r.tsk = ID_W'(t); r.last = l;
      pending.push_back(r);
    endfunction

    function void note_command(logic [1:0] f, int t, int s, int id, int p);
      int fs, b, n, topv;
      case (f)
        FUNC_ASSIGN: begin
          fs = -1;
          if (fill[t] < DEPTH)
            for (int i = 0; i < POOL; i++)
              if (!used[i] && fs < 0) fs = i;
          if (fs < 0) push(KIND_OVERFLOW, t, 0, 0, 0, 1);
          else begin
            used[fs] = 1; owner[fs] = QN_W'(t); spri[fs] = PRI_W'(p); stask[fs] = ID_W'(id);
            fill[t]++;
            push(KIND_SIZE, t, fill[t], 0, 0, 1);
          end
        end
        FUNC_MERGE: begin
          if (fill[s] < threshold) push(KIND_REFUSED, t, 0, 0, 0, 1);
          else if (s != t && fill[t] + fill[s] > DEPTH) push(KIND_OVERFLOW, t, 0, 0, 0, 1);
          else begin
            if (s != t) begin
              for (int i = 0; i < POOL; i++)
                if (used[i] && owner[i] == s) owner[i] = QN_W'(t);
              fill[t] += fill[s];
              fill[s] = 0;
            end
            b = top_slot(t);
            if (b < 0) push(KIND_EMPTY, t, 0, 0, 0, 1);
            else push(KIND_MERGE, t, 0, int'(spri[b]), 0, 1);
          end
        end
        FUNC_EXECUTE: begin
          b = top_slot(t);
          if (b < 0) push(KIND_EMPTY, t, 0, 0, 0, 1);
          else begin
            topv = int'(spri[b]);
            n = 0;
            while (b >= 0 && int'(spri[b]) == topv && n < DEPTH) begin
              used[b] = 0;
              if (fill[t] > 0) fill[t]--;
              push(KIND_EXEC, t, 0, topv, int'(stask[b]), 0);
              n++;
              b = top_slot(t);
            end
            pending[$].last = 1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      n_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  mqps_in_if req_i ();
  mqps_out_if rsp_o ();

  multi_queue_priority_scheduler_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_i.sink), .rsp_o(rsp_o.source)
  );

  always #4 clk_i = ~clk_i;

  sched_scoreboard sb = new();
  bit quiet;
  int n_cmds;

  initial begin
    req_i.valid = 0; req_i.func = '0; req_i.target_queue = '0;
    req_i.source_queue = '0; req_i.task_id = '0; req_i.task_priority = '0;
    rsp_o.ready = 0;
  end

  // result side: random stall bursts, none once quiet
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_o.valid && rsp_o.ready)
        sb.check_result({rsp_o.kind, rsp_o.queue_number, rsp_o.task_count,
                         rsp_o.top_priority, rsp_o.done_task, rsp_o.last});
      if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_o.ready <= 0;
        gap = $urandom_range(1, 18);
        repeat (gap) begin
          @(posedge clk_i);
        end
        rsp_o.ready <= 1;
      end else rsp_o.ready <= 1;
    end
  end

  task automatic send_cmd(logic [1:0] f, int t, int s, int id, int p);
    req_i.valid <= 1; req_i.func <= f; req_i.target_queue <= QN_W'(t);
    req_i.source_queue <= QN_W'(s); req_i.task_id <= ID_W'(id);
    req_i.task_priority <= PRI_W'(p);
    do @(posedge clk_i); while (!req_i.ready);
    sb.note_command(f, t, s, id, p);
    n_cmds++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_i.valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_i.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // extra wait after the last result beat, when execute has already stopped scanning
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_threshold(int v);
    cfg_we_i <= 1; cfg_wdata_i <= CNT_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.threshold = v;
  endtask

  task automatic random_cmd(int qmax);
    int r;
    int t;
    r = $urandom_range(0, 19);
    t = $urandom_range(0, qmax);
    if (r < 11)
      send_cmd(FUNC_ASSIGN, t, $urandom_range(0, 15), $urandom_range(0, 65535),
               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3));
    else if (r < 15)
      send_cmd(FUNC_MERGE, t, $urandom_range(0, qmax), $urandom, $urandom);
    else if (r < 19)
      send_cmd(FUNC_EXECUTE, t, $urandom_range(0, 15), $urandom, $urandom);
    else send_cmd(FUNC_NOP, t, $urandom_range(0, 15), $urandom, $urandom);
  endtask

  initial begin
    sb.clear();
    quiet = 0;
    n_cmds = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty cases, extremes, ties, self merge
    send_cmd(FUNC_EXECUTE, 0, 0, 0, 0);
    send_cmd(FUNC_MERGE, 15, 0, 0, 0);
    send_cmd(FUNC_ASSIGN, 0, 0, 16'hffff, 16'hffff);
    send_cmd(FUNC_ASSIGN, 0, 15, 16'h0000, 16'hffff);
    send_cmd(FUNC_ASSIGN, 0, 0, 16'h0005, 16'h0000);
    send_cmd(FUNC_ASSIGN, 15, 0, 16'h1234, 16'h0007);
    send_cmd(FUNC_MERGE, 0, 0, 0, 0);
    send_cmd(FUNC_MERGE, 0, 15, 0, 0);
    send_cmd(FUNC_NOP, 15, 15, 16'hffff, 16'hffff);
    send_cmd(FUNC_EXECUTE, 0, 0, 0, 0);
    send_cmd(FUNC_EXECUTE, 0, 0, 0, 0);
    send_cmd(FUNC_EXECUTE, 0, 0, 0, 0);
    drain();
    set_threshold(64);
    send_cmd(FUNC_MERGE, 1, 2, 0, 0);
    // fill queue 3 past its depth, then merge into a full queue
    for (int i = 0; i < 65; i++) send_cmd(FUNC_ASSIGN, 3, 0, i, 9);
    drain();
    set_threshold(1);
    send_cmd(FUNC_ASSIGN, 4, 0, 1, 1);
    send_cmd(FUNC_MERGE, 3, 4, 0, 0);
    send_cmd(FUNC_MERGE, 4, 3, 0, 0);
    drain();
    // random phases with varying thresholds, last phase without idling
    for (int ph = 0; ph < 4; ph++) begin
      set_threshold(ph == 3 ? 0 : $urandom_range(0, 4));
      for (int i = 0; i < 16; i++) begin
        if (ph == 3) quiet = 1;
        random_cmd(ph == 1 ? 3 : 15);
      end
      for (int q = 0; q < NQ && ph == 2; q++) send_cmd(FUNC_EXECUTE, q, 0, 0, 0);
      drain();
    end
    drain();
    $display("covered %0d commands and %0d result beats, thresholds 0..64, full queue",
             n_cmds, sb.n_results);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #120000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== multi_queue_priority_scheduler_unit.f =====
+incdir+design
design/mqps_pkg.sv
design/mqps_if.sv
design/mqps_best.sv
design/multi_queue_priority_scheduler_unit.sv
sim/tb_multi_queue_priority_scheduler_unit.sv
